// ===== design/page_range_coalescing_table_top_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the page range coalescing table checker
// ----------------------------------------------------------------------------
`ifndef PAGE_RANGE_COALESCING_TABLE_TOP_ASSERT_SVH
`define PAGE_RANGE_COALESCING_TABLE_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is held
`define PRCT_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held
`define PRCT_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/prct_pkg.sv =====
// ----------------------------------------------------------------------------
// prct_pkg
// Shared constants, codes and controller/datapath interface types for the
// page range coalescing table.
// ----------------------------------------------------------------------------
`default_nettype none

package prct_pkg;

    // Table geometry
    localparam int ENTRIES  = 16;
    localparam int IDX_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W    = $clog2(ENTRIES + 1);

    // Field widths
    localparam int ADDR_W   = 48;
    localparam int LEN_W    = 49;
    localparam int CALC_W   = LEN_W + 1;
    localparam int SHIFT_W  = 5;
    localparam int INDEX_W  = 8;
    localparam int COUNT_W  = 9;

    localparam logic [SHIFT_W-1:0] SHIFT_RESET = 5'd12;

    // Stream widths
    localparam int S_TDATA_W = 48;
    localparam int S_TUSER_W = 1;
    localparam int M_TDATA_W = 120;
    localparam int M_TUSER_W = 2;

    // Result tdata layout (lowest bit first)
    localparam int OUT_IDX_LSB  = 0;
    localparam int OUT_BASE_LSB = OUT_IDX_LSB + INDEX_W;
    localparam int OUT_LEN_LSB  = OUT_BASE_LSB + ADDR_W;
    localparam int OUT_CNT_LSB  = OUT_LEN_LSB + LEN_W;

    // Result tuser layout
    localparam int OUT_FOUND_BIT = 0;
    localparam int OUT_FULL_BIT  = 1;

    // Request kinds
    localparam logic ACT_ADD    = 1'b0;
    localparam logic ACT_LOOKUP = 1'b1;

    // Controller to datapath
    typedef struct packed {
        logic capture;   // latch the accepted request
        logic compare;   // latch the priority pick over all entries
        logic update;    // write the table and load the result register
    } prct_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic out_free;  // result register empty or drained this cycle
    } prct_sts_t;

endpackage

`default_nettype wire

// ===== design/page_range_coalescing_table_top.sv =====
// ----------------------------------------------------------------------------
// page_range_coalescing_table_top
// Table of page-aligned address regions with add (coalesce) and lookup.
// ----------------------------------------------------------------------------
// Each request passes a compare state, which checks the address against all
// 16 regions in parallel and latches the first match, then an update state,
// which extends, appends or reports that region and
// loads the result register, while the next request is accepted in that
// same cycle. A result waiting in the output register stalls only the
// update cycle of the following request. The region table needs no clearing
// after reset; only the region count is cleared. page_shift is written
// through the cfg port (always ready) and should change only while idle.
// ----------------------------------------------------------------------------
`default_nettype none

module page_range_coalescing_table_top (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    // request stream
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    input  wire logic [prct_pkg::S_TDATA_W-1:0]     s_tdata,  // [47:0] address
    input  wire logic [prct_pkg::S_TUSER_W-1:0]     s_tuser,  // [0] action
    // page_shift write
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [prct_pkg::SHIFT_W-1:0]       cfg_data,
    // result stream
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // [7:0] entry_index, [55:8] region_base, [104:56] region_length,
    // [113:105] entry_count, [119:114] zero
    output logic [prct_pkg::M_TDATA_W-1:0]          m_tdata,
    output logic [prct_pkg::M_TUSER_W-1:0]          m_tuser   // [0] found, [1] table_full
);

    prct_pkg::prct_cmd_t cmd;
    prct_pkg::prct_sts_t sts;

    assign cfg_ready = 1'b1;

    prct_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    prct_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .sts       (sts),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

`default_nettype wire

// ===== design/prct_ctrl.sv =====
// ----------------------------------------------------------------------------
// prct_ctrl
// Sequencer: accept, compare all entries, update at most one entry and emit result.
// ----------------------------------------------------------------------------
`default_nettype none

module prct_ctrl (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire prct_pkg::prct_sts_t sts,
    output prct_pkg::prct_cmd_t     cmd
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_CMP  = 3'b010,
        ST_UPD  = 3'b100
    } state_t;

    state_t state_reg, state_next;

    // A new request may enter while the previous one retires
    always_comb begin
        s_tready    = (state_reg == ST_IDLE) ||
                      ((state_reg == ST_UPD) && sts.out_free);
        cmd.capture = s_tvalid && s_tready;
        cmd.compare = (state_reg == ST_CMP);
        cmd.update  = (state_reg == ST_UPD) && sts.out_free;
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (cmd.capture) state_next = ST_CMP;
            end
            ST_CMP: begin
                state_next = ST_UPD;
            end
            ST_UPD: begin
                if (sts.out_free) state_next = cmd.capture ? ST_CMP : ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= ST_IDLE;
        else          state_reg <= state_next;
    end

endmodule

`default_nettype wire

// ===== design/prct_dp.sv =====
// ----------------------------------------------------------------------------
// prct_dp
// Datapath: region table, parallel window compare with priority pick,
// region extend/append arithmetic, page size register and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module prct_dp (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire prct_pkg::prct_cmd_t                cmd,
    output prct_pkg::prct_sts_t                     sts,
    input  wire logic [prct_pkg::S_TDATA_W-1:0]     s_tdata,
    input  wire logic [prct_pkg::S_TUSER_W-1:0]     s_tuser,
    input  wire logic                               cfg_valid,
    input  wire logic [prct_pkg::SHIFT_W-1:0]       cfg_data,
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    output logic [prct_pkg::M_TDATA_W-1:0]          m_tdata,
    output logic [prct_pkg::M_TUSER_W-1:0]          m_tuser
);

    localparam int CW = prct_pkg::CALC_W;

    // Page size register
    logic [prct_pkg::SHIFT_W-1:0] page_shift_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn)       page_shift_reg <= prct_pkg::SHIFT_RESET;
        else if (cfg_valid) page_shift_reg <= cfg_data;
    end

    logic [CW-1:0] page;
    logic [CW-1:0] page_mask;
    assign page      = CW'(1) << page_shift_reg;
    assign page_mask = page - CW'(1);

    // Region table (contents undefined until written)
    logic [prct_pkg::ADDR_W-1:0] base_mem [prct_pkg::ENTRIES];
    logic [prct_pkg::LEN_W-1:0]  len_mem  [prct_pkg::ENTRIES];
    logic [prct_pkg::CNT_W-1:0]  count_reg, count_next;

    // Captured request
    logic                        act_reg;
    logic [prct_pkg::ADDR_W-1:0] addr_reg;

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            act_reg  <= s_tuser[0];
            addr_reg <= s_tdata[prct_pkg::ADDR_W-1:0];
        end
    end

    logic [CW-1:0] addr_x;
    assign addr_x = CW'(addr_reg);

    // Per-entry compare lanes
    logic [prct_pkg::ENTRIES-1:0] match;

    for (genvar g = 0; g < prct_pkg::ENTRIES; g++) begin : g_lane
        logic [CW-1:0] b_x;
        logic [CW-1:0] e_x;
        logic          in_region;
        logic          in_window;
        logic          live;

        assign b_x       = CW'(base_mem[g]);
        assign e_x       = b_x + CW'(len_mem[g]);
        assign in_region = (b_x <= addr_x) && (addr_x < e_x);
        // lower bound base - page saturates at zero
        assign in_window = ((addr_x + page) >= b_x) && (addr_x < (e_x + page));
        assign live      = prct_pkg::CNT_W'(g) < count_reg;
        assign match[g]  = live &&
                           ((act_reg == prct_pkg::ACT_LOOKUP) ? in_region : in_window);
    end

    // First matching entry wins
    logic                       pick_hit;
    logic [prct_pkg::IDX_W-1:0] pick_idx;

    always_comb begin
        pick_hit = 1'b0;
        pick_idx = '0;
        for (int i = prct_pkg::ENTRIES - 1; i >= 0; i--) begin
            if (match[i]) begin
                pick_hit = 1'b1;
                pick_idx = prct_pkg::IDX_W'(i);
            end
        end
    end

    // Compare stage registers
    logic                        hit_reg;
    logic [prct_pkg::IDX_W-1:0]  idx_reg;
    logic [prct_pkg::ADDR_W-1:0] sel_base_reg;
    logic [prct_pkg::LEN_W-1:0]  sel_len_reg;

    always_ff @(posedge aclk) begin
        if (cmd.compare) begin
            hit_reg      <= pick_hit;
            idx_reg      <= pick_idx;
            sel_base_reg <= base_mem[pick_idx];
            sel_len_reg  <= len_mem[pick_idx];
        end
    end

    // Update arithmetic
    logic [CW-1:0] sel_b_x, sel_l_x;
    logic [CW-1:0] page_base;
    logic [CW-1:0] len_down, len_down_max;
    logic [CW-1:0] want_up, len_up_max;

    assign sel_b_x      = CW'(sel_base_reg);
    assign sel_l_x      = CW'(sel_len_reg);
    assign page_base    = addr_x & ~page_mask;
    // extend down: keep the end, move the base to the address's page
    assign len_down     = sel_l_x + (sel_b_x - page_base);
    assign len_down_max = (len_down > page) ? len_down : page;
    // extend up: cover through the end of the address's page
    assign want_up      = ((addr_x - sel_b_x) + page) & ~page_mask;
    assign len_up_max   = (want_up > sel_l_x) ? want_up : sel_l_x;

    logic                          res_found, res_full;
    logic [prct_pkg::INDEX_W-1:0]  res_idx;
    logic [prct_pkg::ADDR_W-1:0]   res_base;
    logic [prct_pkg::LEN_W-1:0]    res_len;
    logic                          wr_en;
    logic [prct_pkg::IDX_W-1:0]    wr_idx;

    always_comb begin
        res_found  = 1'b0;
        res_full   = 1'b0;
        res_idx    = '0;
        res_base   = '0;
        res_len    = '0;
        wr_en      = 1'b0;
        wr_idx     = idx_reg;
        count_next = count_reg;
        case (act_reg)
            prct_pkg::ACT_LOOKUP: begin
                if (hit_reg) begin
                    res_found = 1'b1;
                    res_idx   = prct_pkg::INDEX_W'(idx_reg);
                    res_base  = sel_base_reg;
                    res_len   = sel_len_reg;
                end
            end
            prct_pkg::ACT_ADD: begin
                if (hit_reg) begin
                    res_found = 1'b1;
                    res_idx   = prct_pkg::INDEX_W'(idx_reg);
                    wr_en     = 1'b1;
                    if (addr_x < sel_b_x) begin
                        res_base = page_base[prct_pkg::ADDR_W-1:0];
                        res_len  = len_down_max[prct_pkg::LEN_W-1:0];
                    end else begin
                        res_base = sel_base_reg;
                        res_len  = len_up_max[prct_pkg::LEN_W-1:0];
                    end
                end else if (count_reg >= prct_pkg::CNT_W'(prct_pkg::ENTRIES)) begin
                    res_full = 1'b1;
                end else begin
                    // append a one-page region
                    wr_en      = 1'b1;
                    wr_idx     = count_reg[prct_pkg::IDX_W-1:0];
                    res_idx    = prct_pkg::INDEX_W'(count_reg);
                    res_base   = page_base[prct_pkg::ADDR_W-1:0];
                    res_len    = page[prct_pkg::LEN_W-1:0];
                    count_next = count_reg + prct_pkg::CNT_W'(1);
                end
            end
            default: begin
            end
        endcase
    end

    // Table write
    always_ff @(posedge aclk) begin
        if (cmd.update && wr_en) begin
            base_mem[wr_idx] <= res_base;
            len_mem[wr_idx]  <= res_len;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn)        count_reg <= '0;
        else if (cmd.update) count_reg <= count_next;
    end

    // Result register
    logic                            m_valid_reg;
    logic [prct_pkg::M_TDATA_W-1:0]  m_data_reg, m_data_next;
    logic [prct_pkg::M_TUSER_W-1:0]  m_user_reg, m_user_next;

    assign m_data_next = prct_pkg::M_TDATA_W'({prct_pkg::COUNT_W'(count_next),
                                               res_len, res_base, res_idx});
    assign m_user_next = {res_full, res_found};

    always_ff @(posedge aclk) begin
        if (!aresetn)        m_valid_reg <= 1'b0;
        else if (cmd.update) m_valid_reg <= 1'b1;
        else if (m_tready)   m_valid_reg <= 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (cmd.update) begin
            m_data_reg <= m_data_next;
            m_user_reg <= m_user_next;
        end
    end

    assign sts.out_free = !m_valid_reg || m_tready;
    assign m_tvalid     = m_valid_reg;
    assign m_tdata      = m_data_reg;
    assign m_tuser      = m_user_reg;

endmodule

`default_nettype wire

// ===== design/prct_checker.sv =====
// ----------------------------------------------------------------------------
// prct_checker
// Port-level checks for the page range coalescing table, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

`include "page_range_coalescing_table_top_assert.svh"

module prct_checker (
    input wire logic                               aclk,
    input wire logic                               aresetn,
    input wire logic                               s_tvalid,
    input wire logic                               s_tready,
    input wire logic                               m_tvalid,
    input wire logic                               m_tready,
    input wire logic [prct_pkg::M_TDATA_W-1:0]     m_tdata,
    input wire logic [prct_pkg::M_TUSER_W-1:0]     m_tuser
);

    logic                         r_found, r_full;
    logic [prct_pkg::INDEX_W-1:0] r_idx;
    logic [prct_pkg::COUNT_W-1:0] r_count;

    assign r_found = m_tuser[prct_pkg::OUT_FOUND_BIT];
    assign r_full  = m_tuser[prct_pkg::OUT_FULL_BIT];
    assign r_idx   = m_tdata[prct_pkg::OUT_IDX_LSB +: prct_pkg::INDEX_W];
    assign r_count = m_tdata[prct_pkg::OUT_CNT_LSB +: prct_pkg::COUNT_W];

    // held result stays presented
    `PRCT_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid,
                      "result dropped while stalled")

    // one request in compare at a time
    `PRCT_ASSERT_NEXT(a_one_in_flight, aclk, aresetn, s_tvalid && s_tready, !s_tready,
                      "request accepted during compare cycle")

    `PRCT_ASSERT_NOW(a_flags_excl, aclk, aresetn, m_tvalid, !(r_found && r_full),
                     "found and table_full both set")

    `PRCT_ASSERT_NOW(a_full_count, aclk, aresetn, m_tvalid && r_full,
                     r_count == prct_pkg::COUNT_W'(prct_pkg::ENTRIES),
                     "table_full with table not full")

    `PRCT_ASSERT_NOW(a_idx_range, aclk, aresetn, m_tvalid && r_found,
                     prct_pkg::COUNT_W'(r_idx) < r_count,
                     "matched index beyond valid regions")

endmodule

bind page_range_coalescing_table_top prct_checker u_prct_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire
